FILE: src/kv_cache_attention_decode_unit_macros.svh
// assertion macros for the kv cache attention decode unit
// no dependencies; included by the modules that assert
`ifndef KV_CACHE_ATTENTION_DECODE_UNIT_MACROS_SVH
`define KV_CACHE_ATTENTION_DECODE_UNIT_MACROS_SVH

// same-cycle implication
`define KVAD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KVAD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/kvad_pkg.sv
// shared types and constants of the kv cache attention decode unit
// no dependencies
package kvad_pkg;

   localparam logic       MODE_APPEND = 1'b0;
   localparam logic       MODE_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic       REG_DIM_IN_USE = 1'b0;
   localparam logic [9:0] DIM_RESET      = 10'd768;

   localparam int         SCORE_W    = 48;
   localparam int         WSUM_W     = 48;
   localparam int         NUM_W      = 64;
   localparam int         WEIGHT_W   = 31;
   localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;
   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
   localparam logic [63:0] ROUND_Q29    = 64'h2000_0000;
   localparam int         IDX_SHIFT  = 20;
   localparam int         IDX_ROUND  = 1 << 19;

   localparam logic [2:0] DRAIN_CYCLES = 3'd6;
   localparam logic [3:0] DIV_STEPS    = 4'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCORE,
      ST_SCORE_DRAIN,
      ST_WEIGHT,
      ST_WEIGHT_DRAIN,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       key_we;
      logic       val_we;
      logic       q_we;
      logic       mac_issue;
      logic       mac_first;
      logic       mac_last;
      logic       wt_issue;
      logic       wt_first;
      logic       div_init;
      logic       div_step;
      logic       out_load;
      logic       out_use_quot;
      logic [1:0] out_status;
   } dp_cmd_type;

endpackage

FILE: src/kvad_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module kvad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/kvad_datapath.sv
// datapath: cache memories, multiply-accumulate, exp weighting, divider, result register
// depends on kvad_pkg and kvad_ram
module kvad_datapath #(
   parameter int MAX_DIM         = 768,
   parameter int MAX_ROWS        = 256,
   parameter int EXP_TABLE_DEPTH = 256,
   localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int KW = (MAX_ROWS * MAX_DIM > 1) ? $clog2(MAX_ROWS * MAX_DIM) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kvad_pkg::dp_cmd_type     cmd,
   input  logic [KW-1:0]            key_waddr,
   input  logic [RW-1:0]            val_waddr,
   input  logic [EW-1:0]            q_waddr,
   input  logic [KW-1:0]            key_raddr,
   input  logic [EW-1:0]            q_raddr,
   input  logic [RW-1:0]            mac_row,
   input  logic [RW-1:0]            wt_row,
   input  logic [8:0]               out_rows,
   input  logic signed [15:0]       key_elem,
   input  logic signed [15:0]       value_elem,
   input  logic signed [15:0]       query_elem,
   output logic signed [15:0]       attention_out,
   output logic [8:0]               rows_used,
   output logic [1:0]               status
);

   localparam int SW = kvad_pkg::SCORE_W;
   localparam int WSW = kvad_pkg::WSUM_W;
   localparam int NW = kvad_pkg::NUM_W;
   localparam int WTW = kvad_pkg::WEIGHT_W;
   localparam int XW = $clog2(EXP_TABLE_DEPTH);

   function automatic logic [EXP_TABLE_DEPTH-1:0][WTW-1:0] exp_rom_build();
      logic [EXP_TABLE_DEPTH-1:0][WTW-1:0] t;
      logic [63:0] p;
      t[0] = kvad_pkg::ONE_Q30;
      for (int i = 1; i < EXP_TABLE_DEPTH; i++) begin
         p = 64'(t[i-1]) * kvad_pkg::EXP_STEP_Q30 + kvad_pkg::ROUND_Q29;
         t[i] = WTW'(p >> 30);
      end
      return t;
   endfunction

   localparam logic [EXP_TABLE_DEPTH-1:0][WTW-1:0] EXP_ROM = exp_rom_build();

   logic [15:0] k_rdata, q_rdata, v_rdata;
   logic [SW-1:0] s_rdata;

   // pass one pipeline
   logic m1_vld_ff, m1_first_ff, m1_last_ff;
   logic [RW-1:0] m1_row_ff;
   logic m2_vld_ff, m2_first_ff, m2_last_ff;
   logic [RW-1:0] m2_row_ff;
   logic signed [31:0] prod_ff;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic sc_vld_ff;
   logic [RW-1:0] sc_row_ff;
   logic signed [SW-1:0] max_ff;

   // pass two pipeline
   logic w1_vld_ff, w1_first_ff;
   logic w2_vld_ff, w2_first_ff;
   logic [SW-1:0] d_ff;
   logic signed [15:0] v2_ff;
   logic w3_vld_ff, w3_first_ff;
   logic [WTW-1:0] wt_ff, wt_in;
   logic signed [15:0] v3_ff;
   logic [SW:0] idx_sum;
   logic [SW:0] idx;
   logic w4_vld_ff, w4_first_ff;
   logic signed [47:0] wprod_ff;
   logic [WTW-1:0] wt4_ff;
   logic [WSW-1:0] wsum_ff;
   logic signed [NW-1:0] num_ff;

   // divider
   logic [NW-1:0] rem_ff, dvs_ff, mag, dividend;
   logic [15:0] quo_ff;
   logic ovf_ff, neg_ff;
   logic [15:0] quot_res;

   logic signed [15:0] att_ff;
   logic [8:0] rows_ff;
   logic [1:0] status_ff;

   kvad_ram #(.WIDTH(16), .DEPTH(MAX_ROWS * MAX_DIM)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.key_we),
      .wr_addr (key_waddr),
      .wr_data (key_elem),
      .rd_addr (key_raddr),
      .rd_data (k_rdata)
   );

   kvad_ram #(.WIDTH(16), .DEPTH(MAX_ROWS)) u_val_ram (
      .clock   (clock),
      .wr_en   (cmd.val_we),
      .wr_addr (val_waddr),
      .wr_data (value_elem),
      .rd_addr (wt_row),
      .rd_data (v_rdata)
   );

   kvad_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_query_ram (
      .clock   (clock),
      .wr_en   (cmd.q_we),
      .wr_addr (q_waddr),
      .wr_data (query_elem),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   kvad_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS)) u_score_ram (
      .clock   (clock),
      .wr_en   (sc_vld_ff),
      .wr_addr (sc_row_ff),
      .wr_data (acc_ff),
      .rd_addr (wt_row),
      .rd_data (s_rdata)
   );

   assign acc_in = (m2_first_ff ? SW'(0) : acc_ff) + SW'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         sc_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= cmd.mac_issue;
         m2_vld_ff <= m1_vld_ff;
         sc_vld_ff <= m2_vld_ff & m2_last_ff;
      end
      m1_first_ff <= cmd.mac_first;
      m1_last_ff  <= cmd.mac_last;
      m1_row_ff   <= mac_row;
      m2_first_ff <= m1_first_ff;
      m2_last_ff  <= m1_last_ff;
      m2_row_ff   <= m1_row_ff;
      prod_ff     <= $signed(q_rdata) * $signed(k_rdata);
      sc_row_ff   <= m2_row_ff;
      if (m2_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (sc_vld_ff && (sc_row_ff == '0 || acc_ff > max_ff)) begin
         max_ff <= acc_ff;
      end
   end

   assign idx_sum = {1'b0, d_ff} + (SW+1)'(kvad_pkg::IDX_ROUND);
   assign idx = idx_sum >> kvad_pkg::IDX_SHIFT;

   always_comb begin
      wt_in = '0;
      if (idx < (SW+1)'(EXP_TABLE_DEPTH)) begin
         wt_in = EXP_ROM[idx[XW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_vld_ff <= 1'b0;
         w2_vld_ff <= 1'b0;
         w3_vld_ff <= 1'b0;
         w4_vld_ff <= 1'b0;
      end else begin
         w1_vld_ff <= cmd.wt_issue;
         w2_vld_ff <= w1_vld_ff;
         w3_vld_ff <= w2_vld_ff;
         w4_vld_ff <= w3_vld_ff;
      end
      w1_first_ff <= cmd.wt_first;
      w2_first_ff <= w1_first_ff;
      w3_first_ff <= w2_first_ff;
      w4_first_ff <= w3_first_ff;
      d_ff        <= SW'(max_ff - $signed(s_rdata));
      v2_ff       <= v_rdata;
      wt_ff       <= wt_in;
      v3_ff       <= v2_ff;
      wprod_ff    <= $signed({1'b0, wt_ff}) * v3_ff;
      wt4_ff      <= wt_ff;
      if (w4_vld_ff) begin
         wsum_ff <= (w4_first_ff ? WSW'(0) : wsum_ff) + WSW'(wt4_ff);
         num_ff  <= (w4_first_ff ? NW'(0) : num_ff) + NW'(wprod_ff);
      end
   end

   assign mag = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   assign dividend = mag + NW'(wsum_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= dividend;
         dvs_ff <= NW'({wsum_ff, 15'b0});
         ovf_ff <= dividend >= NW'({wsum_ff, 16'b0});
         neg_ff <= num_ff[NW-1];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_ff <= rem_ff - dvs_ff;
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
         dvs_ff <= dvs_ff >> 1;
      end
   end

   always_comb begin
      if (!neg_ff) begin
         quot_res = (ovf_ff || quo_ff > 16'd32767) ? 16'h7FFF : quo_ff;
      end else begin
         quot_res = (ovf_ff || quo_ff > 16'd32768) ? 16'h8000 : 16'(-quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         att_ff    <= cmd.out_use_quot ? quot_res : 16'sd0;
         rows_ff   <= out_rows;
         status_ff <= cmd.out_status;
      end
   end

   assign attention_out = att_ff;
   assign rows_used = rows_ff;
   assign status = status_ff;

endmodule

FILE: src/kvad_controller.sv
// controller: vector bookkeeping, query sequencing, result handshake
// depends on kvad_pkg and the assertion macro header
`include "kv_cache_attention_decode_unit_macros.svh"

module kvad_controller #(
   parameter int MAX_DIM  = 768,
   parameter int MAX_ROWS = 256,
   localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   localparam int KW = (MAX_ROWS * MAX_DIM > 1) ? $clog2(MAX_ROWS * MAX_DIM) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [9:0]           dim_in_use,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kvad_pkg::dp_cmd_type cmd,
   output logic [KW-1:0]        key_waddr,
   output logic [RW-1:0]        val_waddr,
   output logic [EW-1:0]        q_waddr,
   output logic [KW-1:0]        key_raddr,
   output logic [EW-1:0]        q_raddr,
   output logic [RW-1:0]        mac_row,
   output logic [RW-1:0]        wt_row,
   output logic [8:0]           out_rows
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int DCW = (DW > 10) ? DW : 10;
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int BW = $clog2(MAX_ROWS * MAX_DIM + 1);

   kvad_pkg::state_type state_ff, state_in;
   logic cur_mode_ff, cur_mode_in;
   logic [EW-1:0] elem_ctr_ff, elem_ctr_in;
   logic [RCW-1:0] row_count_ff, row_count_in;
   logic [BW-1:0] base_ff, base_in;
   logic [RW-1:0] r_ff, r_in;
   logic [EW-1:0] e_ff, e_in;
   logic [BW-1:0] rbase_ff, rbase_in;
   logic [2:0] drain_ff, drain_in;
   logic [3:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [DCW-1:0] dim_wide;
   logic [DW-1:0] dim_eff;
   logic accept, out_free, not_full, vec_last, e_last, r_last;
   logic [EW-1:0] pos;

   always_comb begin
      dim_wide = DCW'(dim_in_use);
      if (dim_wide == '0) begin
         dim_eff = DW'(1);
      end else if (dim_wide > DCW'(MAX_DIM)) begin
         dim_eff = DW'(MAX_DIM);
      end else begin
         dim_eff = DW'(dim_wide);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign not_full = row_count_ff < RCW'(MAX_ROWS);
   assign pos = (req_mode != cur_mode_ff) ? '0 : elem_ctr_ff;
   assign vec_last = ((DW+1)'(pos) + 1'b1) >= (DW+1)'(dim_eff);
   assign e_last = ((DW+1)'(e_ff) + 1'b1) >= (DW+1)'(dim_eff);
   assign r_last = (RCW'(r_ff) + 1'b1) == row_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kvad_pkg::ST_IDLE: begin
            if (accept && vec_last && req_mode == kvad_pkg::MODE_QUERY
                  && row_count_ff != '0) begin
               state_in = kvad_pkg::ST_SCORE;
            end
         end
         kvad_pkg::ST_SCORE: begin
            if (e_last && r_last) begin
               state_in = kvad_pkg::ST_SCORE_DRAIN;
            end
         end
         kvad_pkg::ST_SCORE_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = kvad_pkg::ST_WEIGHT;
            end
         end
         kvad_pkg::ST_WEIGHT: begin
            if (r_last) begin
               state_in = kvad_pkg::ST_WEIGHT_DRAIN;
            end
         end
         kvad_pkg::ST_WEIGHT_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = kvad_pkg::ST_DIV_INIT;
            end
         end
         kvad_pkg::ST_DIV_INIT: begin
            state_in = kvad_pkg::ST_DIV_STEP;
         end
         kvad_pkg::ST_DIV_STEP: begin
            if (step_ff == '0) begin
               state_in = kvad_pkg::ST_DONE;
            end
         end
         kvad_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = kvad_pkg::ST_IDLE;
            end
         end
         default: state_in = kvad_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      out_rows = 9'(row_count_ff);
      key_waddr = KW'(base_ff + BW'(pos));
      val_waddr = RW'(row_count_ff);
      q_waddr = pos;
      key_raddr = KW'(rbase_ff + BW'(e_ff));
      q_raddr = e_ff;
      mac_row = r_ff;
      wt_row = r_ff;
      unique case (state_ff)
         kvad_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (accept) begin
               if (req_mode == kvad_pkg::MODE_APPEND) begin
                  cmd.key_we = not_full;
                  cmd.val_we = not_full && pos == '0;
                  if (vec_last) begin
                     cmd.out_load = 1'b1;
                     if (not_full) begin
                        out_rows = 9'(row_count_ff + 1'b1);
                        cmd.out_status = kvad_pkg::STATUS_OK;
                     end else begin
                        cmd.out_status = kvad_pkg::STATUS_FULL;
                     end
                  end
               end else begin
                  cmd.q_we = 1'b1;
                  if (vec_last && row_count_ff == '0) begin
                     cmd.out_load = 1'b1;
                     cmd.out_status = kvad_pkg::STATUS_EMPTY;
                  end
               end
            end
         end
         kvad_pkg::ST_SCORE: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_first = e_ff == '0;
            cmd.mac_last = e_last;
         end
         kvad_pkg::ST_WEIGHT: begin
            cmd.wt_issue = 1'b1;
            cmd.wt_first = r_ff == '0;
         end
         kvad_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
         kvad_pkg::ST_DIV_STEP: cmd.div_step = 1'b1;
         kvad_pkg::ST_DONE: begin
            cmd.out_load = out_free;
            cmd.out_use_quot = 1'b1;
            cmd.out_status = kvad_pkg::STATUS_OK;
         end
         default: cmd = '0;
      endcase
   end

   // counters and bookkeeping
   always_comb begin
      cur_mode_in = cur_mode_ff;
      elem_ctr_in = elem_ctr_ff;
      row_count_in = row_count_ff;
      base_in = base_ff;
      r_in = r_ff;
      e_in = e_ff;
      rbase_in = rbase_ff;
      drain_in = drain_ff;
      step_in = step_ff;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      unique case (state_ff)
         kvad_pkg::ST_IDLE: begin
            r_in = '0;
            e_in = '0;
            rbase_in = '0;
            if (accept) begin
               cur_mode_in = req_mode;
               elem_ctr_in = vec_last ? '0 : EW'(pos + 1'b1);
               if (vec_last && req_mode == kvad_pkg::MODE_APPEND && not_full) begin
                  row_count_in = row_count_ff + 1'b1;
                  base_in = base_ff + BW'(MAX_DIM);
               end
            end
         end
         kvad_pkg::ST_SCORE: begin
            drain_in = kvad_pkg::DRAIN_CYCLES - 1'b1;
            if (e_last) begin
               e_in = '0;
               r_in = r_ff + 1'b1;
               rbase_in = rbase_ff + BW'(MAX_DIM);
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         kvad_pkg::ST_SCORE_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            r_in = '0;
         end
         kvad_pkg::ST_WEIGHT: begin
            drain_in = kvad_pkg::DRAIN_CYCLES - 1'b1;
            r_in = r_ff + 1'b1;
         end
         kvad_pkg::ST_WEIGHT_DRAIN: drain_in = drain_ff - 1'b1;
         kvad_pkg::ST_DIV_INIT: step_in = kvad_pkg::DIV_STEPS;
         kvad_pkg::ST_DIV_STEP: step_in = step_ff - 1'b1;
         kvad_pkg::ST_DONE: step_in = step_ff;
         default: step_in = step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvad_pkg::ST_IDLE;
         cur_mode_ff  <= kvad_pkg::MODE_APPEND;
         elem_ctr_ff  <= '0;
         row_count_ff <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_mode_ff  <= cur_mode_in;
         elem_ctr_ff  <= elem_ctr_in;
         row_count_ff <= row_count_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff     <= r_in;
      e_ff     <= e_in;
      rbase_ff <= rbase_in;
      drain_ff <= drain_in;
      step_ff  <= step_in;
   end

   assign rsp_valid = rsp_valid_ff;

   `KVAD_ASSERT_IMP(a_rows_bound, clock, reset, 1'b1, row_count_ff <= RCW'(MAX_ROWS), "row count above capacity")
   `KVAD_ASSERT_IMP(a_elem_bound, clock, reset, 1'b1, DW'(elem_ctr_ff) < DW'(MAX_DIM), "element counter out of range")
   `KVAD_ASSERT_IMP(a_score_rows, clock, reset, state_ff == kvad_pkg::ST_SCORE, row_count_ff != '0, "scoring an empty cache")
   `KVAD_ASSERT_NXT(a_done_delivers, clock, reset, state_ff == kvad_pkg::ST_DONE && out_free, rsp_valid_ff, "query result not presented")

endmodule

FILE: src/kv_cache_attention_decode_unit.sv
// top level of the kv cache attention decode unit: csr port, controller and datapath
// depends on kvad_pkg, kvad_controller, kvad_datapath
//
// Elements arrive one per transaction. An append vector stores a key row and its
// first value element; a query vector is buffered and, on its last element, scored
// against every cached row. Append and empty-cache results appear in the cycle after
// the last element is taken. A query over the cached rows is scored by the single
// multiply-accumulate unit that walks the key memory one element per cycle, followed
// by one weighting pass of one row per cycle and a 16-step divider. No new
// transaction is taken while a query runs.
module kv_cache_attention_decode_unit #(
   parameter int MAX_DIM         = 768,
   parameter int MAX_ROWS        = 256,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [15:0] req_key_elem,
   input  logic signed [15:0] req_value_elem,
   input  logic signed [15:0] req_query_elem,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_attention_out,
   output logic [8:0]         rsp_rows_used,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int EW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int KW = (MAX_ROWS * MAX_DIM > 1) ? $clog2(MAX_ROWS * MAX_DIM) : 1;

   logic [9:0] dim_ff, dim_in;
   kvad_pkg::dp_cmd_type cmd;
   logic [KW-1:0] key_waddr, key_raddr;
   logic [RW-1:0] val_waddr, mac_row, wt_row;
   logic [EW-1:0] q_waddr, q_raddr;
   logic [8:0] out_rows;

   always_comb begin
      dim_in = dim_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == kvad_pkg::REG_DIM_IN_USE) begin
         dim_in = csr_pwdata[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= kvad_pkg::DIM_RESET;
      end else begin
         dim_ff <= dim_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == kvad_pkg::REG_DIM_IN_USE) ? {22'b0, dim_ff} : 32'b0;

   kvad_controller #(
      .MAX_DIM  (MAX_DIM),
      .MAX_ROWS (MAX_ROWS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .dim_in_use (dim_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .key_waddr  (key_waddr),
      .val_waddr  (val_waddr),
      .q_waddr    (q_waddr),
      .key_raddr  (key_raddr),
      .q_raddr    (q_raddr),
      .mac_row    (mac_row),
      .wt_row     (wt_row),
      .out_rows   (out_rows)
   );

   kvad_datapath #(
      .MAX_DIM         (MAX_DIM),
      .MAX_ROWS        (MAX_ROWS),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .key_waddr     (key_waddr),
      .val_waddr     (val_waddr),
      .q_waddr       (q_waddr),
      .key_raddr     (key_raddr),
      .q_raddr       (q_raddr),
      .mac_row       (mac_row),
      .wt_row        (wt_row),
      .out_rows      (out_rows),
      .key_elem      (req_key_elem),
      .value_elem    (req_value_elem),
      .query_elem    (req_query_elem),
      .attention_out (rsp_attention_out),
      .rows_used     (rsp_rows_used),
      .status        (rsp_status)
   );

endmodule

FILE: dv/kv_cache_attention_decode_checker.sv
// checker for the kv cache attention decode unit: watches the csr port and both channels,
// predicts each result from its own copy of the cache and compares field by field
// depends on kvad_pkg
`timescale 1ns / 1ps

module kv_cache_attention_decode_checker #(
   parameter int MAX_DIM         = 768,
   parameter int MAX_ROWS        = 256,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_mode,
   input  logic signed [15:0] req_key_elem,
   input  logic signed [15:0] req_value_elem,
   input  logic signed [15:0] req_query_elem,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_attention_out,
   input  logic [8:0]         rsp_rows_used,
   input  logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 errors,
   output int                 pending
);

   localparam logic [2:0] DIM_ADDR = 3'(4 * kvad_pkg::REG_DIM_IN_USE);

   typedef struct packed {
      logic signed [15:0] attention;
      logic [8:0]         rows;
      logic [1:0]         status;
   } attention_result_type;

   logic signed [15:0]   key_mem [MAX_ROWS*MAX_DIM];
   logic signed [15:0]   value_first [MAX_ROWS];
   logic signed [15:0]   query_vec [MAX_DIM];
   longint unsigned      exp_weight [EXP_TABLE_DEPTH];
   int unsigned          cached_rows;
   int unsigned          elem_pos;
   logic                 cur_mode;
   logic [9:0]           dim_setting;
   attention_result_type expected_results [$];

   assign pending = expected_results.size();

   initial begin
      errors = 0;
      exp_weight[0] = 64'(kvad_pkg::ONE_Q30);
      for (int i = 1; i < EXP_TABLE_DEPTH; i++)
         exp_weight[i] = (exp_weight[i-1] * kvad_pkg::EXP_STEP_Q30 + kvad_pkg::ROUND_Q29) >> 30;
   end

   task automatic report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic logic signed [15:0] attend(int unsigned dim);
      longint          score [MAX_ROWS];
      longint          best;
      longint          acc;
      longint unsigned diff, idx, w, wsum, mag, quo;
      longint          num, res;
      best = 0;
      wsum = 0;
      num  = 0;
      for (int r = 0; r < cached_rows; r++) begin
         acc = 0;
         for (int e = 0; e < dim; e++)
            acc += longint'(query_vec[e]) * longint'(key_mem[r*MAX_DIM+e]);
         score[r] = acc;
         if (r == 0 || acc > best) best = acc;
      end
      for (int r = 0; r < cached_rows; r++) begin
         diff = longint'(best - score[r]);
         idx  = (diff + kvad_pkg::IDX_ROUND) >> kvad_pkg::IDX_SHIFT;
         w    = (idx < EXP_TABLE_DEPTH) ? exp_weight[idx] : 0;
         wsum += w;
         num  += longint'(w) * longint'(value_first[r]);
      end
      mag = (num < 0) ? -num : num;
      quo = (mag + wsum / 2) / wsum;
      if (quo > 40000) quo = 40000;
      res = (num < 0) ? -longint'(quo) : longint'(quo);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return 16'(res);
   endfunction

   task automatic take_element();
      int unsigned          dim, pos;
      attention_result_type r;
      dim = (dim_setting == 0) ? 1 : (dim_setting > MAX_DIM) ? MAX_DIM : dim_setting;
      if (req_mode != cur_mode) begin
         cur_mode = req_mode;
         elem_pos = 0;
      end
      pos = (elem_pos >= MAX_DIM) ? MAX_DIM - 1 : elem_pos;
      if (req_mode == kvad_pkg::MODE_APPEND) begin
         if (cached_rows < MAX_ROWS) begin
            key_mem[cached_rows*MAX_DIM+pos] = req_key_elem;
            if (pos == 0) value_first[cached_rows] = req_value_elem;
         end
      end else
         query_vec[pos] = req_query_elem;
      if (pos + 1 < dim) begin
         elem_pos = pos + 1;
         return;
      end
      elem_pos    = 0;
      r.attention = '0;
      r.status    = kvad_pkg::STATUS_OK;
      if (req_mode == kvad_pkg::MODE_APPEND) begin
         if (cached_rows < MAX_ROWS) cached_rows++;
         else r.status = kvad_pkg::STATUS_FULL;
      end else if (cached_rows == 0)
         r.status = kvad_pkg::STATUS_EMPTY;
      else
         r.attention = attend(dim);
      r.rows = 9'(cached_rows);
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      attention_result_type want;
      if (reset) begin
         cached_rows = 0;
         elem_pos    = 0;
         cur_mode    = kvad_pkg::MODE_APPEND;
         dim_setting = kvad_pkg::DIM_RESET;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == DIM_ADDR)
            dim_setting = csr_pwdata[9:0];
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0)
               report("unexpected transaction, status", rsp_status, -1);
            else begin
               want = expected_results.pop_front();
               if (rsp_attention_out !== want.attention)
                  report("attention_out", rsp_attention_out, want.attention);
               if (rsp_rows_used !== want.rows)
                  report("rows_used", rsp_rows_used, want.rows);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready) take_element();
      end
   end
endmodule

FILE: dv/kv_cache_attention_decode_unit_tb.sv
// testbench top for the kv cache attention decode unit: clock, reset, stimulus and verdict
// depends on kvad_pkg, kv_cache_attention_decode_unit and kv_cache_attention_decode_checker
`timescale 1ns / 1ps

module kv_cache_attention_decode_unit_tb;

   localparam logic [2:0] DIM_ADDR  = 3'(4 * kvad_pkg::REG_DIM_IN_USE);
   localparam int         MAX_ROWS  = 256;
   localparam int         STALL_CAP = 20000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_mode = kvad_pkg::MODE_APPEND;
   logic signed [15:0] req_key_elem = '0;
   logic signed [15:0] req_value_elem = '0;
   logic signed [15:0] req_query_elem = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [15:0] rsp_attention_out;
   logic [8:0]         rsp_rows_used;
   logic [1:0]         rsp_status;
   logic               csr_psel = 0;
   logic               csr_penable = 0;
   logic               csr_pwrite = 0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 errors;
   int                 pending;
   int                 gap_pct = 0;
   int                 stall_pct = 0;
   int                 quiet_cycles = 0;
   int                 elements_sent = 0;
   int                 rows_cached = 0;
   int                 shortest_row = 4;

   always #10 clock = ~clock;

   kv_cache_attention_decode_unit uut (.*);

   kv_cache_attention_decode_checker chk (.*);

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_CAP) begin
         $display("simulation failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic pick_idling();
      case ($urandom_range(0, 3))
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 58; stall_pct = 0;  end
         2: begin gap_pct = 0;  stall_pct = 58; end
         default: begin gap_pct = 15; stall_pct = 15; end
      endcase
   endtask

   task automatic send_element(logic m, logic [15:0] k, logic [15:0] v, logic [15:0] q);
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid      <= 1;
      req_mode       <= m;
      req_key_elem   <= k;
      req_value_elem <= v;
      req_query_elem <= q;
      do @(posedge clock); while (!req_ready);
      elements_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_dim(int unsigned d);
      wait_idle();
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_paddr   <= DIM_ADDR;
      csr_pwdata  <= 32'(d);
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic send_vector(logic m, int n);
      for (int i = 0; i < n; i++)
         send_element(m, 16'($urandom), 16'($urandom), 16'($urandom));
      if (m == kvad_pkg::MODE_APPEND) begin
         if (rows_cached < MAX_ROWS) rows_cached++;
         if (n < shortest_row) shortest_row = n;
      end
   endtask

   initial begin
      int d;
      repeat (10) @(negedge clock);
      reset <= 0;

      // empty cache, zero dimension and dimension lowered mid-vector
      set_dim(768);
      send_element(kvad_pkg::MODE_QUERY, 16'h7fff, 16'h7fff, 16'h8000);
      set_dim(0);
      send_element(kvad_pkg::MODE_QUERY, 16'h8000, 16'h8000, 16'h7fff);
      set_dim(1023);
      send_element(kvad_pkg::MODE_APPEND, 16'h7fff, 16'h8000, 16'h0000);
      send_element(kvad_pkg::MODE_APPEND, 16'h8000, 16'h7fff, 16'h0000);
      send_element(kvad_pkg::MODE_APPEND, 16'h0000, 16'hffff, 16'h0000);
      // mode change discards the partial append
      send_element(kvad_pkg::MODE_QUERY, 16'h0000, 16'h0000, 16'h1234);
      set_dim(2);
      send_element(kvad_pkg::MODE_QUERY, 16'h0000, 16'h0000, 16'hedcb);

      // extreme rows and queries at dimension 4
      set_dim(4);
      for (int i = 0; i < 4; i++)
         send_element(kvad_pkg::MODE_APPEND, 16'h7fff, 16'h7fff, 16'h0000);
      for (int i = 0; i < 4; i++)
         send_element(kvad_pkg::MODE_APPEND, 16'h8000, 16'h8000, 16'h0000);
      rows_cached = 2;
      for (int i = 0; i < 4; i++)
         send_element(kvad_pkg::MODE_QUERY, 16'h0000, 16'h0000, 16'h7fff);
      for (int i = 0; i < 4; i++)
         send_element(kvad_pkg::MODE_QUERY, 16'h0000, 16'h0000, 16'h0000);

      // random vectors on a growing cache
      while (elements_sent < 860) begin
         pick_idling();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               d = $urandom_range(shortest_row, 8);
               set_dim(d);
               repeat ($urandom_range(1, 4))
                  if (rows_cached < 40) send_vector(kvad_pkg::MODE_APPEND, d);
            end
            4, 5, 6, 7, 8: begin
               d = $urandom_range(1, shortest_row);
               set_dim(d);
               repeat ($urandom_range(1, 3)) send_vector(kvad_pkg::MODE_QUERY, d);
            end
            default: begin
               // broken vector: partial in one mode, then a whole one in the other
               d = shortest_row;
               set_dim(d);
               if ($urandom_range(0, 1)) begin
                  send_vector(kvad_pkg::MODE_QUERY, $urandom_range(1, d - 1));
                  if (rows_cached < 40) send_vector(kvad_pkg::MODE_APPEND, d);
               end else begin
                  for (int i = $urandom_range(1, d - 1); i > 0; i--)
                     send_element(kvad_pkg::MODE_APPEND, 16'($urandom), 16'($urandom),
                                  16'h0000);
                  send_vector(kvad_pkg::MODE_QUERY, d);
               end
            end
         endcase
      end

      // fill the cache, then drop appends and query the full cache
      set_dim(1);
      while (rows_cached < MAX_ROWS + 4) begin
         if ($urandom_range(0, 39) == 0) pick_idling();
         if ($urandom_range(0, 24) == 0) send_vector(kvad_pkg::MODE_QUERY, 1);
         send_element(kvad_pkg::MODE_APPEND, 16'($urandom), 16'($urandom), 16'($urandom));
         rows_cached++;
      end
      send_vector(kvad_pkg::MODE_QUERY, 1);
      set_dim(0);
      send_vector(kvad_pkg::MODE_APPEND, 1);
      send_vector(kvad_pkg::MODE_QUERY, 1);
      send_vector(kvad_pkg::MODE_QUERY, 1);

      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
